// ----- hw/rtl/sve_pkg.sv -----
package sve_pkg;

  localparam int GRID_SIDE_DEF    = 64;
  localparam int BISECT_STEPS_DEF = 10;
  localparam int FRAC             = 11;
  localparam int COORD_W          = 6;
  localparam int POS_W            = COORD_W + FRAC;
  localparam int TRANS_W          = 21;
  localparam int INV_W            = 20;
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 21;

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic signed [TRANS_W-1:0] trans_t;
  typedef logic [INV_W-1:0]          inv_t;

  // item opcodes
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAPE_ID    = 4'd0,
    CFG_FILL_MODE   = 4'd1,
    CFG_TRANS_X     = 4'd2,
    CFG_TRANS_Y     = 4'd3,
    CFG_TRANS_Z     = 4'd4,
    CFG_INV_SCALE_X = 4'd5,
    CFG_INV_SCALE_Y = 4'd6,
    CFG_INV_SCALE_Z = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic   operation;
    coord_t cell_x;
    coord_t cell_y;
    coord_t cell_z;
  } in_t;

  typedef struct packed {
    logic       solid;
    logic [3:0] owner;
    logic [7:0] edge_x;
    logic [7:0] edge_y;
    logic [7:0] edge_z;
  } out_t;

  // one voxel store entry, edges[0] is the x edge
  typedef struct packed {
    logic            solid;
    logic [3:0]      owner;
    logic [2:0][7:0] edges;
  } cell_t;

endpackage

// ----- hw/rtl/sve_store.sv -----
module sve_store #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output sve_pkg::cell_t rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  sve_pkg::cell_t wr_data
);
  import sve_pkg::*;

  cell_t mem [DEPTH];
  cell_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/sve_eval.sv -----
module sve_eval (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  sve_pkg::pos_t   [2:0]     pos,
  input  sve_pkg::trans_t [2:0]     trans,
  input  sve_pkg::inv_t   [2:0]     inv_scale,
  output logic                      done,
  output logic                      hit
);
  import sve_pkg::*;

  localparam int DIFF_W = TRANS_W + 1;
  localparam int PROD_W = DIFF_W + INV_W + 1;
  localparam int MAG_W  = 27;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ACC_W  = SQ_W + 2;

  logic [1:0]               ax_r;
  logic                     iss_r;
  logic                     v1_r, l1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     v2_r, l2_r, big2_r;
  logic [SQ_W-1:0]          sq_r;
  logic [ACC_W-1:0]         acc_r;
  logic                     ovf_r;
  logic                     done_r, inside_r;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag;
  logic [ACC_W-1:0]         acc_sum;

  // one axis per cycle: difference times inverse scale
  always_comb begin
    diff = $signed({{(DIFF_W-POS_W){1'b0}}, pos[ax_r]})
         - $signed({trans[ax_r][TRANS_W-1], trans[ax_r]});
    prod = PROD_W'(diff) * $signed({{(PROD_W-INV_W){1'b0}}, inv_scale[ax_r]});
  end

  assign mag     = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign acc_sum = acc_r + ACC_W'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r  <= 1'b0;
      ax_r   <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // axis issue
      if (start) begin
        iss_r <= 1'b1;
        ax_r  <= '0;
      end else if (iss_r) begin
        iss_r <= (ax_r != 2'd2);
        ax_r  <= ax_r + 2'd1;
      end
      v1_r   <= iss_r;
      v2_r   <= v1_r;
      done_r <= v2_r && l2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    l1_r   <= (ax_r == 2'd2);
    prod_r <= prod;
    l2_r   <= l1_r;
    big2_r <= |mag[PROD_W-1:MAG_W];
    sq_r   <= mag[MAG_W-1:0] * mag[MAG_W-1:0];
    if (start) begin
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else if (v2_r) begin
      acc_r <= acc_sum;
      ovf_r <= ovf_r | big2_r;
      if (l2_r) begin
        inside_r <= !(ovf_r || big2_r) && (acc_sum < (ACC_W'(1) << SQ_W));
      end
    end
  end

  assign done = done_r;
  assign hit  = inside_r;

endmodule

// ----- hw/rtl/sphere_voxel_edge_crossing.sv -----
// Read item: the cell is read from the store (S_RDC, S_GOTC) and returned on the result strobe.
// Process item: the cell is read and evaluated, then each axis with a lower neighbour reads it and
// may be bisected in BISECT_STEPS steps (shared evaluator); the cell is then written back.
// Cell outside the grid: zero result on the cycle after start.
// Synchronous reset, then a clearing pass over all GRID_SIDE^3 cells (262144) with busy high.
// One item at a time; the next transfer is taken at the edge that ends the result strobe.
module sphere_voxel_edge_crossing #(
  parameter int GRID_SIDE    = sve_pkg::GRID_SIDE_DEF,
  parameter int BISECT_STEPS = sve_pkg::BISECT_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  sve_pkg::in_t                      in_data,
  output logic                              out_valid,
  output sve_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sve_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sve_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sve_pkg::*;

  localparam int DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int JW    = $clog2(BISECT_STEPS + 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RDC   = 10'b0000000100,
    S_GOTC  = 10'b0000001000,
    S_EVC   = 10'b0000010000,
    S_AXIS  = 10'b0000100000,
    S_NRD   = 10'b0001000000,
    S_BIS   = 10'b0010000000,
    S_BEV   = 10'b0100000000,
    S_WR    = 10'b1000000000
  } state_t;

  // configuration
  logic [3:0]   shape_id_r;
  logic         fill_mode_r;
  trans_t [2:0] trans_r;
  inv_t   [2:0] inv_r;

  // sequencer
  state_t          state_r, state_nxt;
  logic            op_r, op_nxt;
  coord_t [2:0]    c_r, c_nxt;
  cell_t           cur_r, cur_nxt;
  logic [1:0]      axis_r, axis_nxt;
  pos_t            p1_r, p1_nxt, p2_r, p2_nxt, p_r, p_nxt;
  logic [JW-1:0]   j_r, j_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_r, out_nxt;

  // store and evaluator hookup
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  cell_t           rd_data, wr_data;
  logic            ev_start, ev_done, ev_inside;
  pos_t [2:0]      ev_pos;

  // helpers
  coord_t [2:0]    in_c, nb_c;
  logic            in_grid;
  pos_t            mid, solid_q, dist_q;
  logic [POS_W-4:0] e_raw;
  logic [8:0]      e_q, oe, e_m;
  logic [7:0]      old_e;
  logic            nb_owned;

  function automatic logic [AW-1:0] cell_addr(coord_t x, coord_t y, coord_t z);
    logic [AW:0] a;
    a = ((AW+1)'(x) * (AW+1)'(GRID_SIDE) + (AW+1)'(y)) * (AW+1)'(GRID_SIDE) + (AW+1)'(z);
    return a[AW-1:0];
  endfunction

  assign in_c[0] = in_data.cell_x;
  assign in_c[1] = in_data.cell_y;
  assign in_c[2] = in_data.cell_z;
  assign in_grid = (9'(in_c[0]) < 9'(GRID_SIDE)) && (9'(in_c[1]) < 9'(GRID_SIDE))
                && (9'(in_c[2]) < 9'(GRID_SIDE));

  always_comb begin
    nb_c         = c_r;
    nb_c[axis_r] = c_r[axis_r] - 6'd1;
  end

  // evaluator point: the cell, with the bisected axis replaced during a step
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ev_pos[a] = (state_r == S_BEV && axis_r == 2'(a)) ? p_r : {c_r[a], {FRAC{1'b0}}};
    end
  end

  // crossing arithmetic
  always_comb begin
    mid     = POS_W'(({1'b0, p1_r} + {1'b0, p2_r}) >> 1);
    solid_q = {(cur_r.solid ? c_r[axis_r] : nb_c[axis_r]), {FRAC{1'b0}}};
    dist_q  = (mid > solid_q) ? mid - solid_q : solid_q - mid;
    e_raw   = dist_q[POS_W-1:3];
    if (e_raw == '0) begin
      e_q = 9'd1;
    end else if (e_raw > (POS_W-3)'(255)) begin
      e_q = 9'd255;
    end else begin
      e_q = 9'(e_raw);
    end
    old_e = cur_r.edges[axis_r];
    oe    = cur_r.solid ? 9'd256 - 9'(old_e) : 9'(old_e);
    e_m   = e_q;
    if (old_e != 8'd0) begin
      if (fill_mode_r) begin
        e_m = (e_q > oe) ? e_q : oe;
      end else begin
        e_m = (e_q < oe) ? e_q : oe;
      end
    end
  end

  assign nb_owned = (rd_data.owner == shape_id_r) || (cur_r.owner == shape_id_r);

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    c_nxt         = c_r;
    cur_nxt       = cur_r;
    axis_nxt      = axis_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    p_nxt         = p_r;
    j_nxt         = j_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = cell_addr(c_r[0], c_r[1], c_r[2]);
    wr_en         = 1'b0;
    wr_addr       = cell_addr(c_r[0], c_r[1], c_r[2]);
    wr_data       = cur_r;
    ev_start      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_grid) begin
            op_nxt    = in_data.operation;
            c_nxt     = in_c;
            state_nxt = S_RDC;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end
        end
      end
      S_RDC: begin
        rd_en     = 1'b1;
        state_nxt = S_GOTC;
      end
      S_GOTC: begin
        cur_nxt = rd_data;
        if (op_r == OP_READ) begin
          out_valid_nxt = 1'b1;
          out_nxt       = {rd_data.solid, rd_data.owner, rd_data.edges[0],
                           rd_data.edges[1], rd_data.edges[2]};
          state_nxt     = S_IDLE;
        end else begin
          ev_start  = 1'b1;
          state_nxt = S_EVC;
        end
      end
      S_EVC: begin
        if (ev_done) begin
          if (ev_inside) begin
            cur_nxt.solid = fill_mode_r;
            cur_nxt.owner = shape_id_r;
          end
          axis_nxt  = 2'd0;
          state_nxt = S_AXIS;
        end
      end
      S_AXIS: begin
        if (c_r[axis_r] == '0) begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = (axis_r == 2'd2) ? S_WR : S_AXIS;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = cell_addr(nb_c[0], nb_c[1], nb_c[2]);
          state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        if (rd_data.solid == cur_r.solid) begin
          cur_nxt.edges[axis_r] = 8'd0;
          axis_nxt  = axis_r + 2'd1;
          state_nxt = (axis_r == 2'd2) ? S_WR : S_AXIS;
        end else if (!nb_owned) begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = (axis_r == 2'd2) ? S_WR : S_AXIS;
        end else begin
          p1_nxt    = solid_q;
          p2_nxt    = {(cur_r.solid ? nb_c[axis_r] : c_r[axis_r]), {FRAC{1'b0}}};
          j_nxt     = '0;
          state_nxt = S_BIS;
        end
      end
      S_BIS: begin
        if (j_r == JW'(BISECT_STEPS)) begin
          cur_nxt.edges[axis_r] = cur_r.solid ? 8'(9'd256 - e_m) : e_m[7:0];
          axis_nxt  = axis_r + 2'd1;
          state_nxt = (axis_r == 2'd2) ? S_WR : S_AXIS;
        end else begin
          p_nxt     = mid;
          ev_start  = 1'b1;
          state_nxt = S_BEV;
        end
      end
      S_BEV: begin
        if (ev_done) begin
          if (ev_inside == fill_mode_r) begin
            p1_nxt = p_r;
          end else begin
            p2_nxt = p_r;
          end
          j_nxt     = j_r + JW'(1);
          state_nxt = S_BIS;
        end
      end
      S_WR: begin
        wr_en         = 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = {cur_r.solid, cur_r.owner, cur_r.edges[0], cur_r.edges[1],
                         cur_r.edges[2]};
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    c_r    <= c_nxt;
    cur_r  <= cur_nxt;
    axis_r <= axis_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    p_r    <= p_nxt;
    j_r    <= j_nxt;
    out_r  <= out_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_id_r  <= 4'd1;
      fill_mode_r <= 1'b1;
      trans_r     <= '0;
      for (int a = 0; a < 3; a++) begin
        inv_r[a] <= INV_W'(65536);
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHAPE_ID:    shape_id_r  <= cfg_data[3:0];
        CFG_FILL_MODE:   fill_mode_r <= cfg_data[0];
        CFG_TRANS_X:     trans_r[0]  <= cfg_data[TRANS_W-1:0];
        CFG_TRANS_Y:     trans_r[1]  <= cfg_data[TRANS_W-1:0];
        CFG_TRANS_Z:     trans_r[2]  <= cfg_data[TRANS_W-1:0];
        CFG_INV_SCALE_X: inv_r[0]    <= cfg_data[INV_W-1:0];
        CFG_INV_SCALE_Y: inv_r[1]    <= cfg_data[INV_W-1:0];
        CFG_INV_SCALE_Z: inv_r[2]    <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  sve_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  sve_eval u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ev_start),
    .pos      (ev_pos),
    .trans    (trans_r),
    .inv_scale(inv_r),
    .done     (ev_done),
    .hit      (ev_inside)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a result is only strobed once the sequencer is back at rest
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // every transfer leads to work or a result on the next cycle
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("accepted item dropped");

  // evaluator completions only land where the sequencer waits for them
  a_ev_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    ev_done |-> (state_r == S_EVC || state_r == S_BEV)) else $error("stray evaluator done");

  // bisection never runs past its step count
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BIS) |-> (j_r <= JW'(BISECT_STEPS))) else $error("bisection overrun");
`endif

endmodule

// ----- sim/tb_sphere_voxel_edge_crossing.sv -----
module tb_sphere_voxel_edge_crossing;
  import sve_pkg::*;

  localparam int NCELLS     = 64 * 64 * 64;
  localparam int STEPS      = BISECT_STEPS_DEF;
  localparam int NPHASES    = 10;
  localparam int PHASE_ITEMS = 200;
  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sphere_voxel_edge_crossing u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the voxel store and shape registers
  cell_t  vox [NCELLS];
  logic [3:0] sh_id;
  bit     fill;
  longint ctr [3];
  longint inv [3];

  out_t   cell_q [$];
  int     errors = 0;
  longint cycles = 0;

  // directed rows
  typedef struct {
    bit   op;
    int   x, y, z;
    bit   typed;
    out_t want;
  } row_t;

  function automatic bit in_sphere(longint px, longint py, longint pz);
    longint p [3];
    longint d, m;
    longint unsigned sum;
    p[0] = px; p[1] = py; p[2] = pz;
    sum = 0;
    for (int a = 0; a < 3; a++) begin
      d = (p[a] - ctr[a]) * inv[a];
      m = (d < 0) ? -d : d;
      if (m >= (64'sd1 <<< 27)) return 1'b0;
      sum += longint'(m) * longint'(m);
    end
    return sum < (64'd1 << 54);
  endfunction

  // applies one item to the shadow store and returns the cell afterwards
  function automatic out_t voxel_apply(in_t it);
    int c [3];
    int o [3];
    int ci, oi;
    longint solid_q, empty_q, p1, p2, p, span, e, oe;
    longint pp [3];
    out_t r;
    c[0] = it.cell_x; c[1] = it.cell_y; c[2] = it.cell_z;
    ci = (c[0] * 64 + c[1]) * 64 + c[2];
    if (it.operation == OP_PROCESS) begin
      if (in_sphere(c[0] * 2048, c[1] * 2048, c[2] * 2048)) begin
        vox[ci].solid = fill;
        vox[ci].owner = sh_id;
      end
      for (int i = 0; i < 3; i++) begin
        if (c[i] == 0) continue;
        o = c;
        o[i] = c[i] - 1;
        oi = (o[0] * 64 + o[1]) * 64 + o[2];
        if (vox[oi].solid == vox[ci].solid) begin
          vox[ci].edges[i] = 8'd0;
          continue;
        end
        if (vox[oi].owner != sh_id && vox[ci].owner != sh_id) continue;
        solid_q = (vox[ci].solid ? c[i] : o[i]) * 2048;
        empty_q = (vox[ci].solid ? o[i] : c[i]) * 2048;
        p1 = solid_q;
        p2 = empty_q;
        span = 0;
        for (int j = 0; j <= STEPS; j++) begin
          p = (p1 + p2) >>> 1;
          if (j == STEPS) begin
            span = (p > solid_q) ? p - solid_q : solid_q - p;
            break;
          end
          for (int a = 0; a < 3; a++) pp[a] = c[a] * 2048;
          pp[i] = p;
          if (in_sphere(pp[0], pp[1], pp[2]) == fill) p1 = p;
          else p2 = p;
        end
        e = span >>> 3;
        if (e < 1) e = 1;
        if (e > 255) e = 255;
        if (vox[ci].edges[i] != 0) begin
          oe = vox[ci].solid ? 256 - vox[ci].edges[i] : vox[ci].edges[i];
          if (fill) e = (e > oe) ? e : oe;
          else e = (e < oe) ? e : oe;
        end
        vox[ci].edges[i] = vox[ci].solid ? 8'(256 - e) : 8'(e);
      end
    end
    r.solid  = vox[ci].solid;
    r.owner  = vox[ci].owner;
    r.edge_x = vox[ci].edges[0];
    r.edge_y = vox[ci].edges[1];
    r.edge_z = vox[ci].edges[2];
    return r;
  endfunction

  // register write; valid stays high for the caller to drop
  task automatic reg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx) inside
      CFG_SHAPE_ID:  sh_id = d[3:0];
      CFG_FILL_MODE: fill = d[0];
      CFG_TRANS_X, CFG_TRANS_Y, CFG_TRANS_Z: begin
        ctr[idx - CFG_TRANS_X] = longint'($signed(d[20:0]));
      end
      CFG_INV_SCALE_X, CFG_INV_SCALE_Y, CFG_INV_SCALE_Z: begin
        inv[idx - CFG_INV_SCALE_X] = longint'(d[19:0]);
      end
      default: ;
    endcase
  endtask

  // one cell transfer; start stays high for the caller to drop
  task automatic cell_send(in_t it, bit typed, out_t want);
    out_t got;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    got = voxel_apply(it);
    cell_q = {cell_q, (typed ? want : got)};
  endtask

  task automatic idle_gap(bit allow);
    if (allow && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (cell_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (cell_q.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        want = cell_q.pop_front();
        if (out_data.solid !== want.solid) begin
          $error("solid exp %0d got %0d", want.solid, out_data.solid);
          errors++;
        end
        if (out_data.owner !== want.owner) begin
          $error("owner exp %0d got %0d", want.owner, out_data.owner);
          errors++;
        end
        if (out_data.edge_x !== want.edge_x) begin
          $error("edge_x exp %0d got %0d", want.edge_x, out_data.edge_x);
          errors++;
        end
        if (out_data.edge_y !== want.edge_y) begin
          $error("edge_y exp %0d got %0d", want.edge_y, out_data.edge_y);
          errors++;
        end
        if (out_data.edge_z !== want.edge_z) begin
          $error("edge_z exp %0d got %0d", want.edge_z, out_data.edge_z);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    row_t   rows [$];
    row_t   rw;
    in_t    it;
    int     rad, lo [3], hi [3], cc [3];
    bit     calm;
    logic [CFG_DATA_W-1:0] tv [3];
    logic [CFG_DATA_W-1:0] iv [3];

    sh_id = 4'd1;
    fill  = 1'b1;
    for (int a = 0; a < 3; a++) begin
      ctr[a] = 0;
      inv[a] = 65536;
    end
    for (int n = 0; n < NCELLS; n++) vox[n] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // clearing pass after reset
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: origin is inside the unit sphere, far corner is not
    rows = {rows, row_t'{OP_READ,    63, 63, 63, 1, '0}};
    rows = {rows, row_t'{OP_READ,     0,  0,  0, 1, '0}};
    rows = {rows, row_t'{OP_PROCESS,  0,  0,  0, 1, '{1'b1, 4'd1, 8'd0, 8'd0, 8'd0}}};
    rows = {rows, row_t'{OP_PROCESS, 63, 63, 63, 1, '0}};
    rows = {rows, row_t'{OP_PROCESS,  1,  0,  0, 0, '0}};
    rows = {rows, row_t'{OP_PROCESS,  0,  1,  0, 0, '0}};
    rows = {rows, row_t'{OP_PROCESS,  0,  0,  1, 0, '0}};
    rows = {rows, row_t'{OP_PROCESS,  1,  1,  1, 0, '0}};
    rows = {rows, row_t'{OP_PROCESS,  1,  0,  0, 0, '0}};
    rows = {rows, row_t'{OP_READ,     0,  0,  0, 1, '{1'b1, 4'd1, 8'd0, 8'd0, 8'd0}}};
    rows = {rows, row_t'{OP_READ,     1,  0,  0, 0, '0}};
    rows = {rows, row_t'{OP_PROCESS,  0, 63,  0, 0, '0}};
    rows = {rows, row_t'{OP_PROCESS, 63,  0, 63, 0, '0}};
    rows = {rows, row_t'{OP_READ,    42, 21, 42, 1, '0}};
    foreach (rows[k]) begin
      rw = rows[k];
      it.operation = rw.op;
      it.cell_x = coord_t'(rw.x);
      it.cell_y = coord_t'(rw.y);
      it.cell_z = coord_t'(rw.z);
      cell_send(it, rw.typed, rw.want);
      idle_gap(1'b1);
    end
    // sender holds off until every result is in
    drain();

    for (int ph = 0; ph < NPHASES; ph++) begin
      calm = (ph == NPHASES - 1);
      rad  = $urandom_range(24, 1);
      for (int a = 0; a < 3; a++) begin
        cc[a] = $urandom_range(63);
        tv[a] = CFG_DATA_W'(cc[a] * 2048 + $urandom_range(2047));
        iv[a] = CFG_DATA_W'(65536 / rad + $urandom_range(255))
                | (CFG_DATA_W'($urandom_range(1)) << 20);
        lo[a] = (cc[a] - rad - 2 < 0) ? 0 : cc[a] - rad - 2;
        hi[a] = (cc[a] + rad + 2 > 63) ? 63 : cc[a] + rad + 2;
      end
      // register extremes
      if (ph == 1) begin
        for (int a = 0; a < 3; a++) begin
          tv[a] = 21'h0FFFFF;
          iv[a] = 21'd1;
          lo[a] = 54;
          hi[a] = 63;
        end
      end else if (ph == 2) begin
        for (int a = 0; a < 3; a++) begin
          tv[a] = 21'h100000;
          iv[a] = 21'h0FFFFF;
          lo[a] = 0;
          hi[a] = 9;
        end
      end
      reg_write(CFG_SHAPE_ID, CFG_DATA_W'($urandom_range(15, 1))
                | (CFG_DATA_W'($urandom) << 4));
      reg_write(CFG_FILL_MODE, CFG_DATA_W'(ph % 3 != 1)
                | (CFG_DATA_W'($urandom) << 1));
      reg_write(CFG_TRANS_X, tv[0]);
      reg_write(CFG_TRANS_Y, tv[1]);
      reg_write(CFG_TRANS_Z, tv[2]);
      reg_write(CFG_INV_SCALE_X, iv[0]);
      reg_write(CFG_INV_SCALE_Y, iv[1]);
      reg_write(CFG_INV_SCALE_Z, iv[2]);
      cfg_valid <= 1'b0;
      if ($urandom_range(1)) repeat ($urandom_range(9, 1)) @(posedge clk);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 85) begin
          // in a box around the sphere, so neighbours and crossings interact
          it.operation = ($urandom_range(99) < 80) ? OP_PROCESS : OP_READ;
          it.cell_x = coord_t'($urandom_range(hi[0], lo[0]));
          it.cell_y = coord_t'($urandom_range(hi[1], lo[1]));
          it.cell_z = coord_t'($urandom_range(hi[2], lo[2]));
        end else begin
          it = in_t'(($bits(in_t))'($urandom));
        end
        cell_send(it, 1'b0, '0);
        idle_gap(!calm);
      end
      drain();
    end

    start <= 1'b0;
    while (cell_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
